// File: design/mlpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor lock position controller package
// Item types, state type and the codes shared by the controller modules.
// ----------------------------------------------------------------------------
package mlpc_pkg;

   // Command codes carried in an input item.
   localparam logic [2:0] OP_TICK          = 3'd0;
   localparam logic [2:0] OP_LOCK          = 3'd1;
   localparam logic [2:0] OP_UNLOCK        = 3'd2;
   localparam logic [2:0] OP_TOGGLE        = 3'd3;
   localparam logic [2:0] OP_LOCKED_EDGE   = 3'd4;
   localparam logic [2:0] OP_UNLOCKED_EDGE = 3'd5;
   localparam logic [2:0] OP_SENSE         = 3'd6;

   // Bolt positions.
   localparam logic [1:0] POS_LOCKED   = 2'd0;
   localparam logic [1:0] POS_UNLOCKED = 2'd1;
   localparam logic [1:0] POS_JARRED   = 2'd2;

   // Motor drive codes.
   localparam logic [1:0] DRV_STOP   = 2'd0;
   localparam logic [1:0] DRV_LOCK   = 2'd1;
   localparam logic [1:0] DRV_UNLOCK = 2'd2;

   // Status codes reported with each result item.
   localparam logic [2:0] ST_NONE    = 3'd0;
   localparam logic [2:0] ST_STARTED = 3'd1;
   localparam logic [2:0] ST_THERE   = 3'd2;
   localparam logic [2:0] ST_SENSOR  = 3'd3;
   localparam logic [2:0] ST_TIMEOUT = 3'd4;
   localparam logic [2:0] ST_SENSED  = 3'd5;

   // Timeout register value after reset, and the saturation value of the count.
   localparam int unsigned TICK_WIDTH      = 32;
   localparam logic [TICK_WIDTH-1:0] TIMEOUT_RESET = 32'd3000000;
   localparam logic [TICK_WIDTH-1:0] TICK_MAX      = '1;

   typedef struct packed {
      logic [2:0] opcode;
      logic       locked_active;
      logic       unlocked_active;
   } req_type;

   typedef struct packed {
      logic [1:0] position;
      logic [1:0] motor_drive;
      logic [2:0] status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]            position;
      logic                  running;
      logic [1:0]            target;
      logic [TICK_WIDTH-1:0] elapsed;
      logic [1:0]            drive;
   } state_type;

endpackage

// File: design/mlpc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor lock position controller step logic
// Computes the next controller state and the result item for one input item.
// ----------------------------------------------------------------------------
module mlpc_step
   import mlpc_pkg::*;
(
   input  state_type             state_cur,
   input  req_type               item,
   input  logic [TICK_WIDTH-1:0] timeout_ticks,
   output state_type             state_nxt,
   output rsp_type               result
);

   logic [1:0]            goal;
   logic                  is_move;
   logic [TICK_WIDTH-1:0] count_inc;
   logic                  end_active;
   logic [1:0]            end_pos;
   logic [2:0]            status;

   // Goal of a move command; a toggle unlocks only from the locked position.
   always_comb begin
      case (item.opcode)
         OP_LOCK:   goal = POS_LOCKED;
         OP_UNLOCK: goal = POS_UNLOCKED;
         default:   goal = (state_cur.position == POS_LOCKED) ? POS_UNLOCKED : POS_LOCKED;
      endcase
   end

   assign is_move = (item.opcode == OP_LOCK) || (item.opcode == OP_UNLOCK) ||
                    (item.opcode == OP_TOGGLE);

   // Saturating motion tick count.
   assign count_inc = (state_cur.elapsed == TICK_MAX) ? state_cur.elapsed
                                                      : state_cur.elapsed + 1'b1;

   // End sensor that the edge item refers to.
   assign end_active = (item.opcode == OP_LOCKED_EDGE) ? item.locked_active
                                                       : item.unlocked_active;
   assign end_pos    = (item.opcode == OP_LOCKED_EDGE) ? POS_LOCKED : POS_UNLOCKED;

   // Next state and status.
   always_comb begin
      state_nxt = state_cur;
      status    = ST_NONE;
      case (item.opcode)
         OP_TICK: begin
            if (state_cur.running) begin
               state_nxt.elapsed = count_inc;
               if (count_inc > timeout_ticks) begin
                  state_nxt.running  = 1'b0;
                  state_nxt.drive    = DRV_STOP;
                  state_nxt.position = state_cur.target;
                  status             = ST_TIMEOUT;
               end
            end
         end
         OP_LOCK, OP_UNLOCK, OP_TOGGLE: begin
            if (is_move && state_cur.position == goal) begin
               status = ST_THERE;
            end else begin
               state_nxt.position = POS_JARRED;
               state_nxt.target   = goal;
               state_nxt.running  = 1'b1;
               state_nxt.elapsed  = '0;
               state_nxt.drive    = (goal == POS_LOCKED) ? DRV_LOCK : DRV_UNLOCK;
               status             = ST_STARTED;
            end
         end
         OP_LOCKED_EDGE, OP_UNLOCKED_EDGE: begin
            if (end_active) begin
               state_nxt.position = end_pos;
               if (state_cur.running && state_cur.target == end_pos) begin
                  state_nxt.running = 1'b0;
                  state_nxt.drive   = DRV_STOP;
                  state_nxt.target  = POS_JARRED;
                  status            = ST_SENSOR;
               end
            end
         end
         OP_SENSE: begin
            if (item.locked_active) begin
               state_nxt.position = POS_LOCKED;
            end else if (item.unlocked_active) begin
               state_nxt.position = POS_UNLOCKED;
            end else begin
               state_nxt.position = POS_JARRED;
            end
            state_nxt.running = 1'b0;
            state_nxt.drive   = DRV_STOP;
            status            = ST_SENSED;
         end
         default: begin
            status = ST_NONE;
         end
      endcase
   end

   assign result.position    = state_nxt.position;
   assign result.motor_drive = state_nxt.drive;
   assign result.status      = status;

endmodule

// File: design/motor_lock_position_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor lock position controller
// Tracks the position of a motorized bolt and drives its motor.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (req_valid / req_ready / req_data) carry a tick, a lock,
//   unlock or toggle command, an end sensor edge or a position sense.
//   Every item gives exactly one result item (rsp_valid / rsp_ready /
//   rsp_data) with the bolt position, motor drive and a status code.
//   The timeout in ticks is written through csr_wr_en / csr_wr_data while
//   no item is in flight.
//   An item is captured in an input register, processed against the
//   controller state and placed in the result register. One item is
//   accepted per cycle while the receiver takes results; the combinational
//   step logic that updates the state sets that rate.
//   When the receiver stalls, the result register and the input register
//   hold, and req_ready drops once both are full.
//   Synchronous reset empties both registers, returns the bolt to locked
//   with the motor stopped and loads the default timeout of 3000000 ticks.
// ----------------------------------------------------------------------------
module motor_lock_position_controller
   import mlpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [TICK_WIDTH-1:0] csr_wr_data
);

   logic                  in_valid_ff;
   req_type               in_item_ff;
   logic                  out_valid_ff;
   rsp_type               out_item_ff;
   state_type             state_ff;
   state_type             state_in;
   rsp_type               result_in;
   logic [TICK_WIDTH-1:0] timeout_ff;
   logic                  advance;

   // The buffered item moves on when the result register is free or drains.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Step logic for the buffered item.
   mlpc_step u_step (
      .state_cur     (state_ff),
      .item          (in_item_ff),
      .timeout_ticks (timeout_ff),
      .state_nxt     (state_in),
      .result        (result_in)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_item_ff <= req_data;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_item_ff <= result_in;
      end
   end

   // Controller state, updated once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.position <= POS_LOCKED;
         state_ff.running  <= 1'b0;
         state_ff.target   <= POS_JARRED;
         state_ff.elapsed  <= '0;
         state_ff.drive    <= DRV_STOP;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Timeout register.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

endmodule
